FILE: src/crsf_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// CRSF frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRSF_FRAME_RECEIVER_MACROS_SVH
`define CRSF_FRAME_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/crsf_pkg.sv
// ----------------------------------------------------------------------------
// CRSF receiver package
// Types, codes and constants shared by the receiver front, queue and back.
// ----------------------------------------------------------------------------
package crsf_pkg;

  localparam int NUM_CH     = 16;
  localparam int CH_W       = 11;
  localparam int RC_PAYLOAD = 22;
  localparam int PAYLOAD_W  = RC_PAYLOAD * 8;
  localparam int CFG_IDX_W  = 8;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_UPDATE   = 2'd0;
  localparam logic [1:0] KIND_FS_ENTER = 2'd1;
  localparam logic [1:0] KIND_FS_LEAVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ADDRESS     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RC_FRAME_TYPE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_TIMEOUT = 8'd3;

  localparam logic [7:0]  CRC_POLY       = 8'hD5;
  localparam logic [11:0] NEVER_REPORTED = 12'h800;

  typedef struct packed {
    logic [7:0]  sync_address;
    logic [7:0]  rc_frame_type;
    logic [15:0] channel_enable;
    logic [31:0] failsafe_timeout;
  } crsf_cfg_t;

  typedef struct packed {
    logic                 fs_enter;
    logic                 fs_leave;
    logic [PAYLOAD_W-1:0] payload;
  } crsf_cmd_t;

endpackage

FILE: src/crsf_front.sv
// ----------------------------------------------------------------------------
// CRSF receiver front
// Parses bytes into frames, checks length and CRC, runs the idle timer and
// queues failsafe-entry and accepted RC-frame commands for the back.
// ----------------------------------------------------------------------------
module crsf_front #(
  parameter int MAX_FRAME = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  crsf_pkg::crsf_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [7:0]          in_byte,
  output logic                push,
  output crsf_pkg::crsf_cmd_t push_cmd,
  input  logic                q_full
);
  import crsf_pkg::*;

  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME);
  localparam logic [7:0] MIN_RC_LEN = 8'(RC_PAYLOAD + 4);

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]  byte_count;
  logic [7:0]  expected_length;
  logic [7:0]  running_crc;
  logic [7:0]  frame_kind;
  logic [7:0]  payload_store [RC_PAYLOAD];
  logic [31:0] idle_timer;
  logic        rc_seen;
  logic        failsafe_active;

  logic        accept;
  logic [31:0] timer_inc;
  logic        fs_fire;
  logic        frame_ok;
  logic        in_body;
  logic        is_final;
  logic        bad_length;
  logic [7:0]  pay_off;
  logic        pay_wr;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  assign timer_inc  = (idle_timer == 32'hFFFF_FFFF) ? idle_timer : idle_timer + 32'd1;
  assign fs_fire    = rc_seen && (timer_inc > cfg.failsafe_timeout) && !failsafe_active;
  assign frame_ok   = (running_crc == in_byte) && (frame_kind == cfg.rc_frame_type) &&
                      (expected_length >= MIN_RC_LEN);
  assign in_body    = ({1'b0, byte_count} + 9'd1) < {1'b0, expected_length};
  assign is_final   = (byte_count >= 8'd2) && !in_body;
  assign bad_length = (in_byte < 8'd2) || (({1'b0, in_byte} + 9'd2) > MAX_LEN);
  assign pay_off    = byte_count - 8'd3;
  assign pay_wr     = (byte_count >= 8'd3) && (pay_off < 8'(RC_PAYLOAD));

  always_comb begin
    push = 1'b0;
    if (accept) begin
      if (in_op == OP_TICK) begin
        push = fs_fire;
      end else begin
        push = is_final && frame_ok;
      end
    end
  end

  always_comb begin
    push_cmd.fs_enter = (in_op == OP_TICK);
    push_cmd.fs_leave = failsafe_active;
    for (int i = 0; i < RC_PAYLOAD; i++) begin
      push_cmd.payload[i*8 +: 8] = payload_store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      expected_length <= '0;
      running_crc     <= '0;
      frame_kind      <= '0;
      idle_timer      <= '0;
      rc_seen         <= 1'b0;
      failsafe_active <= 1'b0;
    end else if (accept) begin
      if (in_op == OP_TICK) begin
        if (rc_seen) begin
          idle_timer <= timer_inc;
          if (fs_fire) begin
            failsafe_active <= 1'b1;
          end
        end
      end else if (byte_count == 8'd0) begin
        if (in_byte == cfg.sync_address) begin
          byte_count <= 8'd1;
        end
      end else if (byte_count == 8'd1) begin
        if (bad_length) begin
          byte_count <= 8'd0;
        end else begin
          expected_length <= in_byte + 8'd2;
          running_crc     <= 8'd0;
          byte_count      <= 8'd2;
        end
      end else if (in_body) begin
        running_crc <= crc_step(running_crc, in_byte);
        if (byte_count == 8'd2) begin
          frame_kind <= in_byte;
        end
        byte_count <= byte_count + 8'd1;
      end else begin
        if (frame_ok) begin
          idle_timer      <= '0;
          rc_seen         <= 1'b1;
          failsafe_active <= 1'b0;
        end
        byte_count <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_BYTE) && in_body && pay_wr) begin
      payload_store[pay_off[4:0]] <= in_byte;
    end
  end

endmodule

FILE: src/crsf_cmd_queue.sv
// ----------------------------------------------------------------------------
// CRSF command queue
// Two-entry queue of commands between the receiver front and back.
// ----------------------------------------------------------------------------
module crsf_cmd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crsf_pkg::crsf_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output crsf_pkg::crsf_cmd_t cmd
);
  import crsf_pkg::*;

  crsf_cmd_t   entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: src/crsf_back.sv
// ----------------------------------------------------------------------------
// CRSF receiver back
// Executes queued commands: compares channels with the last reported values
// and emits failsafe and channel-update results through an output register.
// ----------------------------------------------------------------------------
module crsf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         channel_enable,
  input  logic                q_valid,
  input  crsf_pkg::crsf_cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [3:0]          out_index,
  output logic [10:0]         out_value,
  output logic                out_last
);
  import crsf_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  logic [1:0]           state;
  logic                 pend_fail;
  logic                 pend_leave;
  logic [NUM_CH-1:0]    mask;
  logic [PAYLOAD_W-1:0] payload;
  logic [11:0]          reported [NUM_CH];

  logic [NUM_CH-1:0]    mask_new;
  logic [NUM_CH-1:0]    low_bit;
  logic [NUM_CH-1:0]    mask_rest;
  logic [3:0]           low_idx;
  logic [CH_W-1:0]      low_val;
  logic                 slot_free;

  assign q_pop     = (state == B_IDLE) && q_valid;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      mask_new[ch] = channel_enable[ch] &&
                     (reported[ch] != {1'b0, payload[ch*CH_W +: CH_W]});
    end
  end

  assign low_bit   = mask & (~mask + 16'd1);
  assign mask_rest = mask & ~low_bit;

  always_comb begin
    low_idx = 4'd0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (low_bit[ch]) begin
        low_idx = 4'(ch);
      end
    end
  end

  assign low_val = payload[low_idx*CH_W +: CH_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      pend_fail  <= 1'b0;
      pend_leave <= 1'b0;
      mask       <= '0;
      out_valid  <= 1'b0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        reported[ch] <= NEVER_REPORTED;
      end
    end else begin
      if (out_valid && out_ready && (state != B_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            pend_fail  <= q_cmd.fs_enter;
            pend_leave <= !q_cmd.fs_enter && q_cmd.fs_leave;
            state      <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (pend_fail) begin
            mask  <= '0;
            state <= B_EMIT;
          end else begin
            mask <= mask_new;
            for (int ch = 0; ch < NUM_CH; ch++) begin
              if (mask_new[ch]) begin
                reported[ch] <= {1'b0, payload[ch*CH_W +: CH_W]};
              end
            end
            state <= (pend_leave || (mask_new != '0)) ? B_EMIT : B_IDLE;
          end
        end
        B_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (pend_fail) begin
              out_kind  <= KIND_FS_ENTER;
              out_index <= '0;
              out_value <= '0;
              out_last  <= 1'b1;
              pend_fail <= 1'b0;
              state     <= B_IDLE;
            end else if (pend_leave) begin
              out_kind   <= KIND_FS_LEAVE;
              out_index  <= '0;
              out_value  <= '0;
              out_last   <= (mask == '0);
              pend_leave <= 1'b0;
              if (mask == '0) begin
                state <= B_IDLE;
              end
            end else begin
              out_kind  <= KIND_UPDATE;
              out_index <= low_idx;
              out_value <= low_val;
              out_last  <= (mask_rest == '0);
              mask      <= mask_rest;
              if (mask_rest == '0) begin
                state <= B_IDLE;
              end
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      payload <= q_cmd.payload;
    end
  end

endmodule

FILE: src/crsf_frame_receiver.sv
// ----------------------------------------------------------------------------
// CRSF frame receiver
// Parses CRSF serial bytes into RC-channel updates and tracks link failsafe.
// ----------------------------------------------------------------------------
// Each serial byte or tick is taken whenever the two-entry command queue has
// room, so input bytes flow at one per cycle. An accepted frame's final byte or
// a timeout tick queues one command; the back takes it in its idle state and
// compares channels in its scan state, then delivers one result per cycle (up
// to seventeen for a frame) through its output register while the sink is ready.
// The output handshake paces the back.
`include "crsf_frame_receiver_macros.svh"

module crsf_frame_receiver #(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] channel_index, [14:4] channel_value
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import crsf_pkg::*;

  crsf_cfg_t   cfg;
  logic        q_push;
  crsf_cmd_t   q_push_cmd;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  crsf_cmd_t   q_cmd;
  logic [3:0]  out_index;
  logic [10:0] out_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_address     <= 8'd200;
      cfg.rc_frame_type    <= 8'd22;
      cfg.channel_enable   <= 16'hFFFF;
      cfg.failsafe_timeout <= 32'd1000000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SYNC_ADDRESS:     cfg.sync_address     <= cfg_data[7:0];
        REG_RC_FRAME_TYPE:    cfg.rc_frame_type    <= cfg_data[7:0];
        REG_CHANNEL_ENABLE:   cfg.channel_enable   <= cfg_data[15:0];
        REG_FAILSAFE_TIMEOUT: cfg.failsafe_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  crsf_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .q_full   (q_full)
  );

  crsf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .cmd      (q_cmd)
  );

  crsf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .channel_enable (cfg.channel_enable),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_kind       (m_axis_tuser),
    .out_index      (out_index),
    .out_value      (out_value),
    .out_last       (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_value, out_index};

  `CRSF_ASSERT_NOW(a_queue_no_overflow, q_push, !q_full, "command pushed into a full queue")
  `CRSF_ASSERT_NEXT(a_queue_holds_push, q_push && !q_pop, q_valid, "pushed command was lost")
  `CRSF_ASSERT_NOW(a_status_zero_data, m_axis_tvalid && (m_axis_tuser != KIND_UPDATE), m_axis_tdata == 16'd0, "status result carries channel data")
  `CRSF_ASSERT_NOW(a_kind_code, m_axis_tvalid, (m_axis_tuser == KIND_UPDATE) || (m_axis_tuser == KIND_FS_ENTER) || (m_axis_tuser == KIND_FS_LEAVE), "result kind out of range")

endmodule

FILE: test/crsf_frame_checker.sv
// ----------------------------------------------------------------------------
// CRSF frame receiver checker
// Watches the byte, result and register channels of the receiver. It keeps
// its own copy of the parser, timer and register state, works out the updates
// and failsafe events that each accepted byte or tick must cause, and compares
// every result transaction against the oldest outstanding one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsf_frame_checker #(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          failures,
  output int          pending
);
  import crsf_pkg::*;

  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0]      ch_index;
    logic [CH_W-1:0] ch_value;
    logic            last_flag;
  } link_event_t;

  link_event_t events_due[$];
  link_event_t step_events[NUM_CH+1];
  int          step_count;

  logic [7:0]  sync_reg;
  logic [7:0]  rc_type_reg;
  logic [15:0] enable_reg;
  logic [31:0] timeout_reg;

  int          byte_pos;
  int          frame_len;
  logic [7:0]  crc_acc;
  logic [7:0]  frame_type;
  logic [7:0]  payload [RC_PAYLOAD];
  logic [11:0] last_sent [NUM_CH];
  logic [31:0] idle_ticks;
  logic        rc_live;
  logic        in_failsafe;

  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    failures++;
  endtask

  task automatic add_event(input logic [1:0] kind, input logic [3:0] idx,
                           input logic [CH_W-1:0] val);
    step_events[step_count] = '{kind, idx, val, 1'b0};
    step_count++;
  endtask

  task automatic accept_rc_frame();
    logic [PAYLOAD_W-1:0] bits;
    logic [CH_W-1:0]      v;
    idle_ticks = '0;
    rc_live = 1'b1;
    if (in_failsafe) begin
      in_failsafe = 1'b0;
      add_event(KIND_FS_LEAVE, 4'd0, '0);
    end
    for (int k = 0; k < RC_PAYLOAD; k++) begin
      bits[k*8 +: 8] = payload[k];
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      v = bits[ch*CH_W +: CH_W];
      if (enable_reg[ch] && last_sent[ch] != {1'b0, v}) begin
        last_sent[ch] = {1'b0, v};
        add_event(KIND_UPDATE, 4'(ch), v);
      end
    end
  endtask

  task automatic decode_stream_item(input logic op, input logic [7:0] b);
    step_count = 0;
    if (op == OP_TICK) begin
      if (rc_live) begin
        if (idle_ticks != 32'hFFFF_FFFF) idle_ticks++;
        if (idle_ticks > timeout_reg && !in_failsafe) begin
          in_failsafe = 1'b1;
          add_event(KIND_FS_ENTER, 4'd0, '0);
        end
      end
    end else if (byte_pos == 0) begin
      if (b == sync_reg) byte_pos = 1;
    end else if (byte_pos == 1) begin
      if (int'(b) < 2 || int'(b) + 2 > MAX_FRAME) begin
        byte_pos = 0;
      end else begin
        frame_len = int'(b) + 2;
        crc_acc = '0;
        byte_pos = 2;
      end
    end else if (byte_pos + 1 < frame_len) begin
      crc_acc = crc8_d5(crc_acc, b);
      if (byte_pos == 2) frame_type = b;
      else if (byte_pos - 3 < RC_PAYLOAD) payload[byte_pos-3] = b;
      byte_pos++;
    end else begin
      if (crc_acc == b && frame_type == rc_type_reg && frame_len >= RC_PAYLOAD + 4)
        accept_rc_frame();
      byte_pos = 0;
    end
    if (step_count > 0) step_events[step_count-1].last_flag = 1'b1;
    for (int k = 0; k < step_count; k++) begin
      events_due.push_back(step_events[k]);
    end
  endtask

  task automatic check_event(input logic [15:0] tdata, input logic [1:0] tuser,
                             input logic tlast);
    link_event_t want;
    if (events_due.size() == 0) begin
      report($sformatf("result with none outstanding: kind %0d index %0d value %0d",
                       tuser, tdata[3:0], tdata[14:4]));
      return;
    end
    want = events_due.pop_front();
    if (tuser != want.kind)
      report($sformatf("kind %0d, expected %0d", tuser, want.kind));
    if (tdata[3:0] != want.ch_index)
      report($sformatf("channel index %0d, expected %0d", tdata[3:0], want.ch_index));
    if (tdata[14:4] != want.ch_value)
      report($sformatf("channel value %0d, expected %0d", tdata[14:4], want.ch_value));
    if (tlast != want.last_flag)
      report($sformatf("last %0d, expected %0d", tlast, want.last_flag));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sync_reg    = 8'd200;
      rc_type_reg = 8'd22;
      enable_reg  = 16'hFFFF;
      timeout_reg = 32'd1000000;
      byte_pos    = 0;
      frame_len   = 0;
      crc_acc     = '0;
      frame_type  = '0;
      idle_ticks  = '0;
      rc_live     = 1'b0;
      in_failsafe = 1'b0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        last_sent[ch] = NEVER_REPORTED;
      end
      events_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_event(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_ADDRESS:     sync_reg = cfg_data[7:0];
          REG_RC_FRAME_TYPE:    rc_type_reg = cfg_data[7:0];
          REG_CHANNEL_ENABLE:   enable_reg = cfg_data[15:0];
          REG_FAILSAFE_TIMEOUT: timeout_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_stream_item(s_axis_tuser, s_axis_tdata);
    end
    pending = events_due.size();
  end

endmodule

FILE: test/crsf_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// CRSF frame receiver testbench
// Feeds serial bytes and ticks into the receiver in four phases with different
// register settings and handshake idling: length limits and a full RC frame,
// short, corrupted and foreign frames, failsafe entry and exit while the result
// side is held off, and a long-payload frame with ticks and noise. A separate
// checker predicts and compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsf_frame_receiver_tb;
  import crsf_pkg::*;

  localparam int         FRAME_LIMIT   = 64;
  localparam int         MAX_PAY       = FRAME_LIMIT - 4;
  localparam int         QUIET_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         HOLD_CYCLES   = 400;
  localparam logic [7:0] REG_UNMAPPED  = 8'hFC;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int failures;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_orders = 0;
  int stall_taken = 0;
  int stall_left = 0;
  int quiet = 0;

  logic [7:0]      sync_sel = 8'd200;
  logic [7:0]      rc_sel = 8'd22;
  logic [7:0]      pay [MAX_PAY];
  logic [CH_W-1:0] ch_now [NUM_CH];

  crsf_frame_receiver #(
    .MAX_FRAME(FRAME_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  crsf_frame_checker #(
    .MAX_FRAME(FRAME_LIMIT)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .failures(failures),
    .pending(pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (stall_orders != stall_taken) begin
      stall_taken = stall_orders;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_SYNC_ADDRESS:  sync_sel = val[7:0];
      REG_RC_FRAME_TYPE: rc_sel = val[7:0];
      default: ;
    endcase
  endtask

  // Channels not kept get a new value, sometimes one of the range ends.
  task automatic fill_channels(input int keep_pct);
    logic [PAYLOAD_W-1:0] bits;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if ($urandom_range(99) >= keep_pct) begin
        case ($urandom_range(7))
          0:       ch_now[ch] = '0;
          1:       ch_now[ch] = '1;
          default: ch_now[ch] = CH_W'($urandom);
        endcase
      end
      bits[ch*CH_W +: CH_W] = ch_now[ch];
    end
    for (int k = 0; k < MAX_PAY; k++) begin
      pay[k] = (k < RC_PAYLOAD) ? bits[k*8 +: 8] : 8'($urandom);
    end
  endtask

  task automatic send_frame(input logic [7:0] ftype, input int pay_len, input bit bad_crc);
    logic [7:0] crc;
    crc = crc8_step(8'h00, ftype);
    for (int k = 0; k < pay_len; k++) begin
      crc = crc8_step(crc, pay[k]);
    end
    if (bad_crc) crc ^= 8'($urandom_range(1, 255));
    send_item(OP_BYTE, sync_sel);
    send_item(OP_BYTE, 8'(pay_len + 2));
    send_item(OP_BYTE, ftype);
    for (int k = 0; k < pay_len; k++) begin
      send_item(OP_BYTE, pay[k]);
    end
    send_item(OP_BYTE, crc);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_item(($urandom_range(1) == 1) ? OP_TICK : OP_BYTE, 8'($urandom));
  endtask

  task automatic run_phase(input int phase);
    drain();
    unique case (phase)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_ticks(1);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, sync_sel);
        send_item(OP_BYTE, 8'd0);
        send_item(OP_BYTE, sync_sel);
        send_item(OP_BYTE, 8'd1);
        send_item(OP_BYTE, sync_sel);
        send_item(OP_BYTE, 8'(FRAME_LIMIT - 1));
        // A length byte equal to the sync address must not restart the hunt.
        send_item(OP_BYTE, sync_sel);
        send_item(OP_BYTE, sync_sel);
        for (int ch = 0; ch < NUM_CH; ch++) begin
          ch_now[ch] = ch[0] ? '1 : '0;
        end
        fill_channels(100);
        send_frame(rc_sel, RC_PAYLOAD, 1'b0);
      end
      1: begin
        send_idle_pct = 59;
        recv_stall_pct = 0;
        write_reg(REG_SYNC_ADDRESS, 32'h0000_0000);
        write_reg(REG_RC_FRAME_TYPE, 32'h0000_00FF);
        write_reg(REG_CHANNEL_ENABLE, 32'($urandom_range(65535)) | 32'd1);
        write_reg(REG_FAILSAFE_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED, $urandom);
        fill_channels(0);
        send_frame(rc_sel, RC_PAYLOAD - 1, 1'b0);
        fill_channels(30);
        send_frame(rc_sel, RC_PAYLOAD, 1'b1);
        send_frame(rc_sel ^ 8'($urandom_range(1, 255)), 1, 1'b0);
        send_ticks(2);
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 59;
        write_reg(REG_SYNC_ADDRESS, 32'h0000_00FF);
        write_reg(REG_RC_FRAME_TYPE, 32'h0000_0000);
        write_reg(REG_CHANNEL_ENABLE, 32'h0000_0000);
        write_reg(REG_FAILSAFE_TIMEOUT, 32'd0);
        // Hold the result side off so the receiver backs up and stalls its input.
        stall_orders++;
        send_ticks(1);
        fill_channels(0);
        send_frame(rc_sel, RC_PAYLOAD, 1'b0);
        send_ticks(1);
        fill_channels(0);
        send_frame(rc_sel, RC_PAYLOAD, 1'b0);
        send_ticks(1);
      end
      default: begin
        send_idle_pct = 20;
        recv_stall_pct = 20;
        write_reg(REG_SYNC_ADDRESS, $urandom);
        write_reg(REG_RC_FRAME_TYPE, $urandom);
        write_reg(REG_CHANNEL_ENABLE, 32'($urandom_range(65535)) | 32'd1);
        write_reg(REG_FAILSAFE_TIMEOUT, $urandom_range(1, 3));
        fill_channels(40);
        send_frame(rc_sel, RC_PAYLOAD + 1, 1'b0);
        send_ticks(4);
        send_noise(4);
      end
    endcase
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int phase = 0; phase < 4; phase++) begin
      run_phase(phase);
    end
    drain();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
